### rtl/core/cn_ratio_to_db_status_assert.svh
// assertion macros for the c/n readout block
// clocked on aclk, disabled while aresetn is low; no other dependencies
`ifndef CN_RATIO_TO_DB_STATUS_ASSERT_SVH
`define CN_RATIO_TO_DB_STATUS_ASSERT_SVH

`ifndef ASSERT_OFF
`define CNR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cnr assertion failed");
`define CNR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cnr assertion failed");
`else
`define CNR_ASSERT_IMP(lbl, ante, cons)
`define CNR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/cnr_pkg.sv
// shared types, constants and tables for the c/n readout block
// no dependencies
`timescale 1ns / 1ps

package cnr_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SAT_DIV,
        ST_SAT_WAIT,
        ST_SAT_PREP,
        ST_TER_MSB,
        ST_TER_D,
        ST_TER_TMUL,
        ST_TER_TCHK,
        ST_TER_TDIV,
        ST_TER_ACCM,
        ST_TER_ACCS,
        ST_TER_SCALE,
        ST_TER_LG,
        ST_POLY_MUL,
        ST_POLY_ADD,
        ST_DONE
    } cnr_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic signed [31:0] coef;
        logic [4:0]         shift;
        logic               full;
        logic               use_lg;
        logic               last;
    } poly_step_t;

    localparam logic [15:0] SAT_HI        = 16'd37000;
    localparam logic [15:0] SAT_LO        = 16'd3000;
    localparam logic [23:0] TER_LO        = 24'd1404;
    localparam logic [23:0] TER_HI        = 24'd5000000;
    localparam logic [11:0] VAL_SAT_HI    = 12'd100;
    localparam logic [11:0] VAL_SAT_LO    = 12'd91;
    localparam logic [11:0] VAL_TER_LO    = 12'd4000;
    localparam logic [11:0] VAL_TER_HI    = 12'd100;
    localparam logic [11:0] VAL_MAX       = 12'd4095;
    localparam logic [31:0] SAT_G0        = 32'h0000_2000;
    localparam logic [31:0] SAT_VOFS      = 32'h0000_3800;
    localparam logic signed [31:0] SAT_P0 = -32'sd41846;
    localparam logic signed [31:0] TER_P0 = 32'sd5033;
    localparam logic [4:0]  SAT_ITER_MAX  = 5'd16;
    localparam logic [5:0]  TER_K_FIRST   = 6'd2;
    localparam logic [5:0]  TER_K_LAST    = 6'd39;
    localparam logic signed [31:0] K_LN   = 32'sd1165800373;
    localparam logic signed [31:0] K_WHOLE = 32'sd1616142483;
    localparam logic [31:0] K_LG_OFS      = 32'd1130911734;
    localparam logic [31:0] K_LG_BIAS     = 32'd335544320;
    localparam logic [3:0]  POLY_SAT_IDX  = 4'd0;
    localparam logic [3:0]  POLY_TER_IDX  = 4'd5;
    localparam logic [4:0]  SAT_FINAL_SH  = 5'd4;
    localparam logic [4:0]  TER_FINAL_SH  = 5'd12;

    // p = coef + (p * v or p * lg) shifted
    function automatic poly_step_t poly_step(input logic [3:0] idx);
        poly_step_t s;
        s = '{coef: 32'sd0, shift: 5'd0, full: 1'b0, use_lg: 1'b0, last: 1'b1};
        case (idx)
            4'd0: s = '{coef: 32'sd979,     shift: 5'd13, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd1: s = '{coef: 32'sd875,     shift: 5'd14, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd2: s = '{coef: 32'sd6584,    shift: 5'd14, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd3: s = '{coef: -32'sd14590,  shift: 5'd15, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd4: s = '{coef: 32'sd20692,   shift: 5'd13, full: 1'b0, use_lg: 1'b0, last: 1'b1};
            4'd5: s = '{coef: 32'sd8389,    shift: 5'd15, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd6: s = '{coef: 32'sd2294,    shift: 5'd16, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd7: s = '{coef: 32'sd6482166, shift: 5'd10, full: 1'b0, use_lg: 1'b0, last: 1'b0};
            4'd8: s = '{coef: 32'sd8619418, shift: 5'd28, full: 1'b1, use_lg: 1'b1, last: 1'b1};
            default: s = '{coef: 32'sd0, shift: 5'd0, full: 1'b0, use_lg: 1'b0, last: 1'b1};
        endcase
        return s;
    endfunction

    // bit0 signal, bit1 carrier, bit2 viterbi, bit3 sync, bit4 lock
    function automatic logic [4:0] decode_flags(input logic sat, input logic [7:0] st);
        logic [4:0] f;
        f = 5'd0;
        if (sat) begin
            f[0] = ~st[7];
            f[1] = ~(st[6] | st[5]);
            f[2] = ~(st[6] | st[5]);
            f[3] = ~(st[6] | st[5]);
            f[4] = ~st[4];
        end else if (st[7:4] == 4'd0) begin
            f[0] = 1'b1;
            f[1] = 1'b1;
            f[3] = ~st[3];
            f[2] = ~st[2];
            f[4] = ~st[1];
        end
        return f;
    endfunction

endpackage

### rtl/core/cn_ratio_to_db_status.sv
// top level: lock flag decode and c/n sequencer over a shared multiplier and divider
// depends on cnr_pkg, cnr_mul, cnr_div and cn_ratio_to_db_status_assert.svh
`timescale 1ns / 1ps
`include "cn_ratio_to_db_status_assert.svh"

// channel  | valid   | ready   | payload
// request  | s_valid | s_ready | s_req_type, s_status_byte, s_cn_raw
// result   | m_valid | m_ready | m_status_flags, m_cn_valid, m_cn_value
//
// one request at a time; s_ready is high only while the sequencer is idle
// no lock or out-of-range count: ST_CHECK goes straight to ST_DONE, which loads the output register
// satellite: up to 17 newton steps, each one division on the shared divider
// terrestrial: up to 38 series terms, each a multiply and a division on the divider
// a finished result waits in the output register; the next request is taken meanwhile
// synchronous active-low reset clears the sequencer and the output valid

module cn_ratio_to_db_status (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_status_byte,
    input  logic [23:0] s_cn_raw,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_status_flags,
    output logic        m_cn_valid,
    output logic [11:0] m_cn_value
);

    cnr_pkg::cnr_state_t state_reg, state_next;

    logic               sat_reg, sat_next;
    logic [4:0]         flags_reg, flags_next;
    logic [23:0]        cn_reg, cn_next;
    logic [11:0]        res_reg, res_next;
    logic signed [31:0] g_reg, g_next;
    logic signed [31:0] v_reg, v_next;
    logic [31:0]        sq_reg, sq_next;
    logic signed [31:0] term_reg, term_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] lg_reg, lg_next;
    logic signed [31:0] p_reg, p_next;
    logic [4:0]         it_reg, it_next;
    logic [5:0]         k_reg, k_next;
    logic [3:0]         idx_reg, idx_next;
    logic [4:0]         bits_reg, bits_next;
    logic [4:0]         whole_reg, whole_next;
    logic               neg_reg, neg_next;

    logic               m_valid_reg, m_valid_next;
    logic [4:0]         m_flags_reg, m_flags_next;
    logic               m_cnv_reg, m_cnv_next;
    logic [11:0]        m_val_reg, m_val_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    cnr_pkg::div_req_t  div_req;
    cnr_pkg::div_rsp_t  div_rsp;
    cnr_pkg::poly_step_t pstep;

    logic               valid_lock;
    logic [31:0]        x;
    logic signed [31:0] gfix;
    logic [31:0]        sum;
    logic signed [31:0] vnew;
    logic signed [63:0] sh64;
    logic signed [31:0] lo32;
    logic signed [31:0] pnew;
    logic signed [31:0] fin;
    logic signed [31:0] tnew;
    logic signed [31:0] qs;
    logic [31:0]        one;
    logic [31:0]        cn32;
    logic [31:0]        scaled;
    logic [31:0]        lgu;

    cnr_mul u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    cnr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign pstep = cnr_pkg::poly_step(idx_reg);

    always_comb begin
        state_next   = state_reg;
        sat_next     = sat_reg;
        flags_next   = flags_reg;
        cn_next      = cn_reg;
        res_next     = res_reg;
        g_next       = g_reg;
        v_next       = v_reg;
        sq_next      = sq_reg;
        term_next    = term_reg;
        d_next       = d_reg;
        acc_next     = acc_reg;
        lg_next      = lg_reg;
        p_next       = p_reg;
        it_next      = it_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        bits_next    = bits_reg;
        whole_next   = whole_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_flags_next = m_flags_reg;
        m_cnv_next   = m_cnv_reg;
        m_val_next   = m_val_reg;

        mul_a        = p_reg;
        mul_b        = v_reg;
        div_req      = '{start: 1'b0, dividend: sq_reg, divisor: 32'(g_reg)};

        valid_lock   = (flags_reg[1:0] == 2'b11);
        cn32         = {8'd0, cn_reg};
        x            = {16'd0, cn_reg[15:0]} - {16'd0, cnr_pkg::SAT_LO};
        gfix         = (g_reg == 32'sd0) ? 32'sd1 : g_reg;
        sum          = div_rsp.quot + 32'(g_reg);
        vnew         = signed'(sum) >>> 1;
        sh64         = prod >>> pstep.shift;
        lo32         = signed'(prod[31:0]) >>> pstep.shift;
        pnew         = pstep.coef + (pstep.full ? signed'(sh64[31:0]) : lo32);
        fin          = pnew >>> (sat_reg ? cnr_pkg::SAT_FINAL_SH : cnr_pkg::TER_FINAL_SH);
        tnew         = signed'(32'(prod >>> 24));
        qs           = neg_reg ? -signed'(div_rsp.quot) : signed'(div_rsp.quot);
        one          = 32'd1 << bits_reg;
        scaled       = 32'(prod >>> 5);
        lgu          = cnr_pkg::K_LG_OFS - (scaled - 32'(acc_reg)) - cnr_pkg::K_LG_BIAS;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cnr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sat_next   = s_req_type;
                    flags_next = cnr_pkg::decode_flags(s_req_type, s_status_byte);
                    cn_next    = s_cn_raw;
                    state_next = cnr_pkg::ST_CHECK;
                end
            end
            cnr_pkg::ST_CHECK: begin
                if (!valid_lock) begin
                    res_next   = {7'd0, flags_reg};
                    state_next = cnr_pkg::ST_DONE;
                end else if (sat_reg) begin
                    if (cn_reg[15:0] > cnr_pkg::SAT_HI) begin
                        res_next   = cnr_pkg::VAL_SAT_HI;
                        state_next = cnr_pkg::ST_DONE;
                    end else if (cn_reg[15:0] < cnr_pkg::SAT_LO) begin
                        res_next   = cnr_pkg::VAL_SAT_LO;
                        state_next = cnr_pkg::ST_DONE;
                    end else begin
                        g_next     = signed'(cnr_pkg::SAT_G0 + (x >> 1));
                        sq_next    = x << 14;
                        it_next    = 5'd0;
                        state_next = cnr_pkg::ST_SAT_DIV;
                    end
                end else begin
                    if (cn_reg < cnr_pkg::TER_LO) begin
                        res_next   = cnr_pkg::VAL_TER_LO;
                        state_next = cnr_pkg::ST_DONE;
                    end else if (cn_reg > cnr_pkg::TER_HI) begin
                        res_next   = cnr_pkg::VAL_TER_HI;
                        state_next = cnr_pkg::ST_DONE;
                    end else begin
                        state_next = cnr_pkg::ST_TER_MSB;
                    end
                end
            end
            cnr_pkg::ST_SAT_DIV: begin
                g_next     = gfix;
                div_req    = '{start: 1'b1, dividend: sq_reg, divisor: 32'(gfix)};
                state_next = cnr_pkg::ST_SAT_WAIT;
            end
            cnr_pkg::ST_SAT_WAIT: begin
                if (div_rsp.done) begin
                    if (vnew == g_reg || it_reg >= cnr_pkg::SAT_ITER_MAX) begin
                        v_next     = vnew;
                        state_next = cnr_pkg::ST_SAT_PREP;
                    end else begin
                        g_next     = vnew;
                        it_next    = it_reg + 5'd1;
                        state_next = cnr_pkg::ST_SAT_DIV;
                    end
                end
            end
            cnr_pkg::ST_SAT_PREP: begin
                v_next     = v_reg - signed'(cnr_pkg::SAT_VOFS);
                p_next     = cnr_pkg::SAT_P0;
                idx_next   = cnr_pkg::POLY_SAT_IDX;
                state_next = cnr_pkg::ST_POLY_MUL;
            end
            cnr_pkg::ST_TER_MSB: begin
                bits_next = 5'd0;
                for (int i = 0; i < 24; i++) begin
                    if (cn_reg[i]) begin
                        bits_next = 5'(i + 1);
                    end
                end
                state_next = cnr_pkg::ST_TER_D;
            end
            cnr_pkg::ST_TER_D: begin
                if (cn_reg[bits_reg - 5'd2]) begin
                    whole_next = bits_reg;
                    d_next     = signed'((one - cn32) << (5'd24 - bits_reg));
                end else begin
                    whole_next = bits_reg - 5'd1;
                    d_next     = -signed'((cn32 - (one >> 1)) << (5'd25 - bits_reg));
                end
                state_next = cnr_pkg::ST_TER_TMUL;
                acc_next   = d_next;
                term_next  = d_next;
                k_next     = cnr_pkg::TER_K_FIRST;
                if (d_next == 32'sd0) begin
                    state_next = cnr_pkg::ST_TER_SCALE;
                end
            end
            cnr_pkg::ST_TER_TMUL: begin
                mul_a      = term_reg;
                mul_b      = d_reg;
                state_next = cnr_pkg::ST_TER_TCHK;
            end
            cnr_pkg::ST_TER_TCHK: begin
                term_next = tnew;
                neg_next  = tnew[31];
                if (tnew == 32'sd0) begin
                    state_next = cnr_pkg::ST_TER_ACCM;
                end else begin
                    div_req = '{start: 1'b1,
                                dividend: tnew[31] ? 32'(-tnew) : 32'(tnew),
                                divisor: {26'd0, k_reg}};
                    state_next = cnr_pkg::ST_TER_TDIV;
                end
            end
            cnr_pkg::ST_TER_TDIV: begin
                if (div_rsp.done) begin
                    acc_next = acc_reg + qs;
                    if (k_reg == cnr_pkg::TER_K_LAST) begin
                        state_next = cnr_pkg::ST_TER_ACCM;
                    end else begin
                        k_next     = k_reg + 6'd1;
                        state_next = cnr_pkg::ST_TER_TMUL;
                    end
                end
            end
            cnr_pkg::ST_TER_ACCM: begin
                mul_a      = acc_reg;
                mul_b      = cnr_pkg::K_LN;
                state_next = cnr_pkg::ST_TER_ACCS;
            end
            cnr_pkg::ST_TER_ACCS: begin
                acc_next   = signed'(32'(prod >>> 28));
                state_next = cnr_pkg::ST_TER_SCALE;
            end
            cnr_pkg::ST_TER_SCALE: begin
                mul_a      = signed'({27'd0, whole_reg});
                mul_b      = cnr_pkg::K_WHOLE;
                state_next = cnr_pkg::ST_TER_LG;
            end
            cnr_pkg::ST_TER_LG: begin
                lg_next    = signed'(lgu);
                v_next     = signed'(lgu) >>> 12;
                p_next     = cnr_pkg::TER_P0;
                idx_next   = cnr_pkg::POLY_TER_IDX;
                state_next = cnr_pkg::ST_POLY_MUL;
            end
            cnr_pkg::ST_POLY_MUL: begin
                mul_a      = p_reg;
                mul_b      = pstep.use_lg ? lg_reg : v_reg;
                state_next = cnr_pkg::ST_POLY_ADD;
            end
            cnr_pkg::ST_POLY_ADD: begin
                p_next = pnew;
                if (pstep.last) begin
                    // negative or too large saturates
                    res_next   = (fin[31:12] != 20'd0) ? cnr_pkg::VAL_MAX : fin[11:0];
                    state_next = cnr_pkg::ST_DONE;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = cnr_pkg::ST_POLY_MUL;
                end
            end
            cnr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_flags_next = flags_reg;
                    m_cnv_next   = valid_lock;
                    m_val_next   = res_reg;
                    state_next   = cnr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cnr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cnr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        sat_reg     <= sat_next;
        flags_reg   <= flags_next;
        cn_reg      <= cn_next;
        res_reg     <= res_next;
        g_reg       <= g_next;
        v_reg       <= v_next;
        sq_reg      <= sq_next;
        term_reg    <= term_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        lg_reg      <= lg_next;
        p_reg       <= p_next;
        it_reg      <= it_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        bits_reg    <= bits_next;
        whole_reg   <= whole_next;
        neg_reg     <= neg_next;
        m_flags_reg <= m_flags_next;
        m_cnv_reg   <= m_cnv_next;
        m_val_reg   <= m_val_next;
    end

    assign s_ready        = (state_reg == cnr_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status_flags = m_flags_reg;
    assign m_cn_valid     = m_cnv_reg;
    assign m_cn_value     = m_val_reg;

    `CNR_ASSERT_IMP(a_flags_echo, m_valid && !m_cn_valid, m_cn_value == {7'd0, m_status_flags})
    `CNR_ASSERT_IMP(a_cn_needs_lock, m_valid && m_cn_valid, m_status_flags[1:0] == 2'b11)
    `CNR_ASSERT_IMP(a_div_idle_start, div_req.start, !div_rsp.busy)
    `CNR_ASSERT_NXT(a_busy_after_req, s_valid && s_ready, !s_ready)

endmodule

### rtl/core/cnr_mul.sv
// shared signed 32x32 multiplier with registered 64-bit product
// depends on nothing but the clock
`timescale 1ns / 1ps

module cnr_mul (
    input  logic               aclk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod_reg
);

    logic signed [63:0] prod_next;

    always_comb begin
        prod_next = 64'(a) * 64'(b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

### rtl/core/cnr_div.sv
// shared unsigned 32/32 restoring divider, one quotient bit per cycle
// depends on cnr_pkg for the request and response structs
`timescale 1ns / 1ps

module cnr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cnr_pkg::div_req_t req,
    output cnr_pkg::div_rsp_t rsp
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[31]};
        if (req.start) begin
            rem_next  = 33'd0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule
